[hw/rtl/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds in the same cycle as its antecedent
`define VWBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property whose consequent holds in the cycle after its antecedent
`define VWBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/vwbf_pkg.sv]
// shared types and constants of the variable width bit field store
package vwbf_pkg;

  localparam int WORD_BITS  = 64;
  localparam int WIDTH_W    = 7;
  localparam int VALUE_W    = 64;
  localparam int POS_W      = 17;
  localparam int CURSOR_MAX = 131071;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 112;

  // out_tdata field positions
  localparam int RD_LSB     = 0;
  localparam int DONE_LSB   = 64;
  localparam int CUR_LSB    = 71;
  localparam int LEN_LSB    = 88;
  localparam int PAD_LSB    = 105;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_SEEK  = 2'd2
  } req_t;

endpackage

[hw/rtl/vwbf_ram.sv]
// generic single-port-write, registered-read ram
module vwbf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hw/rtl/variable_width_bit_field_store_unit.sv]
// top level of the variable width bit field store
//
//  channel | dir | tdata                                      | tuser
//  in_     | in  | width, value, position                     | req_type
//  out_    | out | read_value, bits_done, cursor_now, length  | overflow
//
// for each item the accept cycle starts the read of the two adjacent words
// at the cursor, and the merge cycle then extracts or merges the field and,
// for a write, writes back the words it covers; one item is in flight at a
// time because the next read depends on the cursor and words this one leaves
// the store is split in an even-word bank and an odd-word bank so both
// words of a field that spans a word boundary move in the same cycle
// a result waiting on out_ holds the merge cycle until it is taken
// reset clears cursor, length and handshake state; the words need no clearing
module variable_width_bit_field_store_unit #(
  parameter int STORE_WORDS = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // width [6:0], value [70:7], position [87:71]
  input  logic [vwbf_pkg::IN_DATA_W-1:0]     in_tdata,
  // req_type [1:0]
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_value [63:0], bits_done [70:64], cursor_now [87:71],
  // stream_length [104:88], zero [111:105]
  output logic [vwbf_pkg::OUT_DATA_W-1:0]    out_tdata,
  // overflow [0]
  output logic                               out_tuser
);

  // bank geometry
  localparam int BANK_DEPTH = (STORE_WORDS + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int IDX_W      = (BANK_AW + 1 > 11) ? BANK_AW + 1 : 11;
  localparam longint CAP    = longint'(STORE_WORDS) * 64;
  localparam longint LIM    = (CAP < vwbf_pkg::CURSOR_MAX) ? CAP : vwbf_pkg::CURSOR_MAX;
  localparam logic [vwbf_pkg::POS_W:0] LIM_V = (vwbf_pkg::POS_W + 1)'(LIM);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;

  // captured request
  logic [1:0]                     req_r;
  logic [vwbf_pkg::WIDTH_W-1:0]   wid_r;
  logic [vwbf_pkg::VALUE_W-1:0]   val_r;
  logic [vwbf_pkg::POS_W-1:0]     pos_r;

  logic [vwbf_pkg::POS_W-1:0]     cursor_r, cursor_nxt;
  logic [vwbf_pkg::POS_W-1:0]     length_r, length_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [vwbf_pkg::VALUE_W-1:0]   rd_r, rd_nxt;
  logic [vwbf_pkg::WIDTH_W-1:0]   done_r, done_nxt;
  logic                           ovf_r, ovf_nxt;

  logic                           accept;
  logic                           fire;

  // word addressing from the cursor
  logic [IDX_W-1:0]               idx;
  logic [IDX_W-2:0]               half;
  logic [IDX_W-2:0]               half_p1;
  logic [BANK_AW-1:0]             addr0;
  logic [BANK_AW-1:0]             addr1;
  logic [5:0]                     off;

  logic [63:0]                    rdata0;
  logic [63:0]                    rdata1;
  logic [63:0]                    hi_word;
  logic [63:0]                    lo_word;
  logic [63:0]                    new_hi;
  logic [63:0]                    new_lo;
  logic [63:0]                    wdata0;
  logic [63:0]                    wdata1;
  logic                           we0;
  logic                           we1;

  // field datapath
  logic [6:0]                     rshift;
  logic [127:0]                   win;
  logic [127:0]                   win_sh;
  logic [63:0]                    field_rd;
  logic [63:0]                    lmask;
  logic [63:0]                    v_top;
  logic [63:0]                    m_top;
  logic [127:0]                   m_win;
  logic [127:0]                   v_win;
  logic [127:0]                   merged;
  logic [vwbf_pkg::POS_W:0]       sum;
  logic                           acc_ovf;
  logic                           seek_ovf;
  logic                           do_write;
  logic                           span;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  assign idx     = IDX_W'(cursor_r[vwbf_pkg::POS_W-1:6]);
  assign half    = idx[IDX_W-1:1];
  assign half_p1 = half + (IDX_W-1)'(1);
  assign addr0   = idx[0] ? half_p1[BANK_AW-1:0] : half[BANK_AW-1:0];
  assign addr1   = half[BANK_AW-1:0];
  assign off     = cursor_r[5:0];

  // hi word is the one holding the cursor, lo the next one
  assign hi_word = idx[0] ? rdata1 : rdata0;
  assign lo_word = idx[0] ? rdata0 : rdata1;

  assign rshift   = 7'(vwbf_pkg::WORD_BITS) - wid_r;
  assign win      = {hi_word, lo_word};
  assign win_sh   = win << off;
  assign field_rd = win_sh[127:64] >> rshift;

  // field placed msb-first at the cursor inside the two-word window
  assign lmask  = {64{1'b1}} >> rshift;
  assign v_top  = (val_r & lmask) << rshift;
  assign m_top  = {64{1'b1}} << rshift;
  assign m_win  = {m_top, 64'd0} >> off;
  assign v_win  = {v_top, 64'd0} >> off;
  assign merged = (win & ~m_win) | v_win;
  assign new_hi = merged[127:64];
  assign new_lo = merged[63:0];
  assign span   = (m_win[63:0] != 64'd0);

  assign sum      = {1'b0, cursor_r} + (vwbf_pkg::POS_W + 1)'(wid_r);
  assign acc_ovf  = (wid_r > 7'(vwbf_pkg::WORD_BITS)) || (sum > LIM_V);
  assign seek_ovf = ({1'b0, pos_r} > LIM_V);
  assign do_write = fire && (req_r == vwbf_pkg::REQ_WRITE) && !acc_ovf && (wid_r != '0);

  assign wdata0 = idx[0] ? new_lo : new_hi;
  assign wdata1 = idx[0] ? new_hi : new_lo;
  assign we0    = do_write && (!idx[0] || span);
  assign we1    = do_write && (idx[0] || span);

  vwbf_ram #(
    .WIDTH (vwbf_pkg::WORD_BITS),
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk   (clk),
    .we    (we0),
    .re    (accept),
    .addr  (addr0),
    .wdata (wdata0),
    .rdata (rdata0)
  );

  vwbf_ram #(
    .WIDTH (vwbf_pkg::WORD_BITS),
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk   (clk),
    .we    (we1),
    .re    (accept),
    .addr  (addr1),
    .wdata (wdata1),
    .rdata (rdata1)
  );

  // request decode and result build
  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    length_nxt    = length_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_nxt        = rd_r;
    done_nxt      = done_r;
    ovf_nxt       = ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          rd_nxt        = '0;
          done_nxt      = '0;
          ovf_nxt       = 1'b0;
          case (req_r) inside
            vwbf_pkg::REQ_READ, vwbf_pkg::REQ_WRITE: begin
              if (acc_ovf) begin
                ovf_nxt = 1'b1;
              end else if (wid_r != '0) begin
                cursor_nxt = sum[vwbf_pkg::POS_W-1:0];
                done_nxt   = wid_r;
                if (req_r == vwbf_pkg::REQ_READ) begin
                  rd_nxt = field_rd;
                end else if (length_r < sum[vwbf_pkg::POS_W-1:0]) begin
                  length_nxt = sum[vwbf_pkg::POS_W-1:0];
                end
              end
            end
            vwbf_pkg::REQ_SEEK: begin
              if (seek_ovf) begin
                ovf_nxt = 1'b1;
              end else begin
                cursor_nxt = pos_r;
              end
            end
            default: begin
              // unknown request: report cursor and length only
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      length_r    <= length_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_r   <= rd_nxt;
    done_r <= done_nxt;
    ovf_r  <= ovf_nxt;
    if (accept) begin
      req_r <= in_tuser;
      wid_r <= in_tdata[6:0];
      val_r <= in_tdata[70:7];
      pos_r <= in_tdata[87:71];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = ovf_r;
  assign out_tdata  = {7'd0, length_r, cursor_r, done_r, rd_r};

endmodule

[hw/rtl/vwbf_checker.sv]
// port-level checks of the bit field store, bound to the top level
`include "assert_macros.svh"

module vwbf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [vwbf_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // stalled result holds
  `VWBF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // one item at a time: no accept right after an accept
  `VWBF_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "input ready during merge cycle")

  // a new result only comes out of a merge cycle
  `VWBF_ASSERT_NOW(a_result_after_merge, clk, rst_n, $rose(out_tvalid), !$past(in_tready), "result without a merge cycle")

  // a refused request moves no data
  `VWBF_ASSERT_NOW(a_refused_empty, clk, rst_n, out_tvalid && out_tuser, out_tdata[vwbf_pkg::CUR_LSB-1:0] == '0, "refused request reports data")

endmodule

bind variable_width_bit_field_store_unit vwbf_checker u_vwbf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[verif/testbench.sv]
// self-checking testbench for the variable width bit field store unit
module testbench;

  localparam int STORE_WORDS = 1024;
  localparam int FIELD_LIMIT =
    (STORE_WORDS * vwbf_pkg::WORD_BITS < vwbf_pkg::CURSOR_MAX) ?
    STORE_WORDS * vwbf_pkg::WORD_BITS : vwbf_pkg::CURSOR_MAX;
  localparam int CLK_PERIOD   = 20;
  localparam int TOTAL_ITEMS  = 450;
  localparam int QUIET_LIMIT  = 1500;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_AT_TAKE = 120;
  localparam int HOLD_CYCLES  = 80;
  localparam int PRINT_LIMIT  = 50;
  // request code the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]                   kind;
    logic [vwbf_pkg::WIDTH_W-1:0] width;
    logic [vwbf_pkg::VALUE_W-1:0] value;
    logic [vwbf_pkg::POS_W-1:0]   position;
    bit                           wait_idle;
  } field_request_t;

  typedef struct {
    logic [vwbf_pkg::VALUE_W-1:0] read_value;
    logic [vwbf_pkg::WIDTH_W-1:0] bits_done;
    logic                         overflow;
    logic [vwbf_pkg::POS_W-1:0]   cursor_now;
    logic [vwbf_pkg::POS_W-1:0]   stream_length;
  } field_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [vwbf_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]                      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [vwbf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;

  field_request_t queued_requests [$];
  field_result_t  pending_results [$];
  field_request_t in_flight;

  // predictor state: the stream seen bit by bit, bit 0 first
  bit          stream_bits [FIELD_LIMIT];
  int unsigned bit_pos = 0;
  int unsigned high_water = 0;

  // stimulus planning state: cursor and which bits hold written data
  bit          touched [FIELD_LIMIT];
  int unsigned plan_cursor = 0;
  int unsigned planned = 0;

  int unsigned mismatches = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  int unsigned taken = 0;
  int unsigned quiet = 0;

  variable_width_bit_field_store_unit #(.STORE_WORDS(STORE_WORDS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // works out the result of one request and moves the predictor state on
  function automatic field_result_t apply_request(field_request_t req);
    field_result_t r;
    int unsigned   w;
    int unsigned   i;
    r = '{default: '0};
    w = 32'(req.width);
    if (req.kind == vwbf_pkg::REQ_READ || req.kind == vwbf_pkg::REQ_WRITE) begin
      if (w > vwbf_pkg::WORD_BITS || bit_pos + w > FIELD_LIMIT) begin
        r.overflow = 1'b1;
      end else if (w != 0) begin
        for (i = 0; i < w; i++) begin
          if (req.kind == vwbf_pkg::REQ_READ) begin
            r.read_value = {r.read_value[vwbf_pkg::VALUE_W-2:0], stream_bits[bit_pos + i]};
          end else begin
            stream_bits[bit_pos + i] = req.value[w - 1 - i];
          end
        end
        bit_pos += w;
        r.bits_done = w[vwbf_pkg::WIDTH_W-1:0];
        if (req.kind == vwbf_pkg::REQ_WRITE && high_water < bit_pos) high_water = bit_pos;
      end
    end else if (req.kind == vwbf_pkg::REQ_SEEK) begin
      if (req.position > FIELD_LIMIT) r.overflow = 1'b1;
      else bit_pos = 32'(req.position);
    end
    r.cursor_now    = bit_pos[vwbf_pkg::POS_W-1:0];
    r.stream_length = high_water[vwbf_pkg::POS_W-1:0];
    return r;
  endfunction

  // appends a request and tracks the cursor so reads stay on written bits
  function automatic void queue_request(logic [1:0] kind, int unsigned w,
                                        logic [63:0] v, int unsigned p, bit wait_idle);
    field_request_t req;
    int unsigned    i;
    req.kind      = kind;
    req.width     = w[vwbf_pkg::WIDTH_W-1:0];
    req.value     = v;
    req.position  = p[vwbf_pkg::POS_W-1:0];
    req.wait_idle = wait_idle;
    queued_requests.push_back(req);
    if (kind == vwbf_pkg::REQ_READ || kind == vwbf_pkg::REQ_WRITE) begin
      if (w <= vwbf_pkg::WORD_BITS && plan_cursor + w <= FIELD_LIMIT) begin
        if (kind == vwbf_pkg::REQ_WRITE) begin
          for (i = 0; i < w; i++) touched[plan_cursor + i] = 1'b1;
        end
        plan_cursor += w;
      end
    end else if (kind == vwbf_pkg::REQ_SEEK && p <= FIELD_LIMIT) begin
      plan_cursor = p;
    end
    planned++;
  endfunction

  function automatic int unsigned written_run(int unsigned p, int unsigned most);
    int unsigned n;
    n = 0;
    while (n < most && p + n < FIELD_LIMIT && touched[p + n]) n++;
    return n;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned rand_pos();
    return $urandom_range(0, (1 << vwbf_pkg::POS_W) - 1);
  endfunction

  // mostly a dense low window, some near the end of the store, some anywhere
  function automatic int unsigned pick_start();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 2) return $urandom_range(0, FIELD_LIMIT);
    if (roll < 5) return $urandom_range(FIELD_LIMIT - 2048, FIELD_LIMIT);
    return $urandom_range(0, 2047);
  endfunction

  function automatic int unsigned write_width();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return vwbf_pkg::WORD_BITS;
    if (roll < 4) return $urandom_range(1, 8);
    return $urandom_range(1, vwbf_pkg::WORD_BITS);
  endfunction

  // gap length: calm stretches with none, else mostly short and a few long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (($time / CLK_PERIOD) % 600 < 150) return 0;
    if (roll < 10) return 0;
    if (roll < 17) return $urandom_range(1, 3);
    if (roll < 19) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // sender: predicts each accepted item, then offers the next one
  always @(posedge clk) begin : feed
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_tvalid && in_tready) pending_results.push_back(apply_request(in_flight));
      if (!in_tvalid || in_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_tvalid <= 1'b0;
        end else if (queued_requests.size() != 0 &&
                     !(queued_requests[0].wait_idle && pending_results.size() != 0)) begin
          in_flight = queued_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {in_flight.position, in_flight.value, in_flight.width};
          in_tuser  <= in_flight.kind;
          tx_wait = idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold so the block backs up
  always @(posedge clk) begin : drain
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        taken++;
        if (taken == HOLD_AT_TAKE) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_wait = idle_len();
      end
    end
  end

  // result checker against the oldest prediction
  always @(posedge clk) begin : check
    field_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing expected",
                      out_tdata[vwbf_pkg::RD_LSB +: vwbf_pkg::VALUE_W], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[vwbf_pkg::RD_LSB +: vwbf_pkg::VALUE_W] !== want.read_value)
          flag_mismatch("read_value", out_tdata[vwbf_pkg::RD_LSB +: vwbf_pkg::VALUE_W],
                        want.read_value);
        if (out_tdata[vwbf_pkg::DONE_LSB +: vwbf_pkg::WIDTH_W] !== want.bits_done)
          flag_mismatch("bits_done",
                        64'(out_tdata[vwbf_pkg::DONE_LSB +: vwbf_pkg::WIDTH_W]),
                        64'(want.bits_done));
        if (out_tuser !== want.overflow)
          flag_mismatch("overflow", 64'(out_tuser), 64'(want.overflow));
        if (out_tdata[vwbf_pkg::CUR_LSB +: vwbf_pkg::POS_W] !== want.cursor_now)
          flag_mismatch("cursor_now", 64'(out_tdata[vwbf_pkg::CUR_LSB +: vwbf_pkg::POS_W]),
                        64'(want.cursor_now));
        if (out_tdata[vwbf_pkg::LEN_LSB +: vwbf_pkg::POS_W] !== want.stream_length)
          flag_mismatch("stream_length",
                        64'(out_tdata[vwbf_pkg::LEN_LSB +: vwbf_pkg::POS_W]),
                        64'(want.stream_length));
        if (out_tdata[vwbf_pkg::OUT_DATA_W-1:vwbf_pkg::PAD_LSB] !== '0)
          flag_mismatch("padding",
                        64'(out_tdata[vwbf_pkg::OUT_DATA_W-1:vwbf_pkg::PAD_LSB]), '0);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned p;
    int unsigned w;
    int unsigned run;
    int unsigned n;
    int unsigned tries;
    int unsigned room;
    int unsigned pick;
    bit          first;
    bit          hold;

    // directed: width zero at reset, word-aligned and word-spanning fields
    queue_request(vwbf_pkg::REQ_READ, 0, '1, '1, 0);
    queue_request(vwbf_pkg::REQ_WRITE, vwbf_pkg::WORD_BITS, '1, 0, 0);
    queue_request(vwbf_pkg::REQ_WRITE, 1, '0, 0, 0);
    queue_request(vwbf_pkg::REQ_WRITE, 63, 64'hfedc_ba98_7654_3210, 0, 0);
    queue_request(vwbf_pkg::REQ_WRITE, 5, '1, 0, 0);     // upper value bits dropped
    queue_request(vwbf_pkg::REQ_SEEK, 0, '0, 60, 0);
    queue_request(vwbf_pkg::REQ_WRITE, vwbf_pkg::WORD_BITS, 64'h0123_4567_89ab_cdef, 0, 0);
    queue_request(vwbf_pkg::REQ_SEEK, 0, '0, 0, 0);
    queue_request(vwbf_pkg::REQ_READ, vwbf_pkg::WORD_BITS, '0, 0, 0);
    queue_request(vwbf_pkg::REQ_READ, 1, '0, 0, 0);
    queue_request(vwbf_pkg::REQ_READ, 63, '0, 0, 0);
    queue_request(vwbf_pkg::REQ_READ, 5, '0, 0, 0);
    queue_request(vwbf_pkg::REQ_SEEK, 0, '0, 30, 0);
    queue_request(vwbf_pkg::REQ_READ, vwbf_pkg::WORD_BITS, '1, '1, 0);  // spans two words
    // widths above a word are refused, unknown request ignored
    queue_request(vwbf_pkg::REQ_READ, vwbf_pkg::WORD_BITS + 1, '0, 0, 0);
    queue_request(vwbf_pkg::REQ_WRITE, 127, '1, 0, 0);
    queue_request(REQ_UNUSED, 127, '1, '1, 0);
    // cursor at the bit limit, seeks past it
    queue_request(vwbf_pkg::REQ_SEEK, 0, '0, FIELD_LIMIT, 0);
    queue_request(vwbf_pkg::REQ_WRITE, 1, '1, 0, 0);
    queue_request(vwbf_pkg::REQ_READ, 0, '0, 0, 0);
    queue_request(vwbf_pkg::REQ_SEEK, 0, '0, FIELD_LIMIT + 1, 0);
    queue_request(vwbf_pkg::REQ_SEEK, 127, '1, (1 << vwbf_pkg::POS_W) - 1, 0);
    // last word of the store, then an access running past the end
    queue_request(vwbf_pkg::REQ_SEEK, 0, '0, FIELD_LIMIT - vwbf_pkg::WORD_BITS, 0);
    queue_request(vwbf_pkg::REQ_WRITE, vwbf_pkg::WORD_BITS, rand64(), 0, 0);
    queue_request(vwbf_pkg::REQ_SEEK, 0, '0, FIELD_LIMIT - vwbf_pkg::WORD_BITS, 0);
    queue_request(vwbf_pkg::REQ_READ, vwbf_pkg::WORD_BITS, '0, 0, 0);
    queue_request(vwbf_pkg::REQ_READ, 1, '0, 0, 0);
    queue_request(vwbf_pkg::REQ_SEEK, 0, '0, FIELD_LIMIT - 40, 0);
    queue_request(vwbf_pkg::REQ_WRITE, vwbf_pkg::WORD_BITS, '1, 0, 0);

    // random: write runs and read runs over written bits, plus noise
    target = TOTAL_ITEMS;
    first = 1'b1;
    while (planned < target) begin
      hold = first || ($urandom_range(0, 19) == 0);
      first = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        queue_request(vwbf_pkg::REQ_SEEK, $urandom_range(0, 127), rand64(), pick_start(),
                      hold);
        n = $urandom_range(1, 6);
        repeat (n) queue_request(vwbf_pkg::REQ_WRITE, write_width(), rand64(), rand_pos(), 0);
      end else if (pick < 8) begin
        run = 0;
        tries = 0;
        while (run == 0 && tries < 40) begin
          p = pick_start();
          run = written_run(p, 384);
          tries++;
        end
        if (run != 0) begin
          queue_request(vwbf_pkg::REQ_SEEK, $urandom_range(0, 127), rand64(), p, hold);
          n = 0;
          while (run != 0 && n < 6) begin
            w = $urandom_range(1, run < vwbf_pkg::WORD_BITS ? run : vwbf_pkg::WORD_BITS);
            if ($urandom_range(0, 9) == 0) w = 0;
            queue_request(vwbf_pkg::REQ_READ, w, rand64(), rand_pos(), 0);
            run -= w;
            n++;
          end
        end
      end else begin
        case ($urandom_range(0, 4))
          0: queue_request(REQ_UNUSED, $urandom_range(0, 127), rand64(), rand_pos(), hold);
          1: queue_request($urandom_range(0, 1) ? vwbf_pkg::REQ_WRITE : vwbf_pkg::REQ_READ,
                           $urandom_range(vwbf_pkg::WORD_BITS + 1, 127), rand64(),
                           rand_pos(), hold);
          2: queue_request(vwbf_pkg::REQ_SEEK, $urandom_range(0, 127), rand64(),
                           $urandom_range(FIELD_LIMIT + 1, (1 << vwbf_pkg::POS_W) - 1), hold);
          3: queue_request($urandom_range(0, 1) ? vwbf_pkg::REQ_WRITE : vwbf_pkg::REQ_READ,
                           0, rand64(), rand_pos(), hold);
          default: begin
            // near the end: a write that may not fit, then, if under a word is left, a read that cannot
            queue_request(vwbf_pkg::REQ_SEEK, $urandom_range(0, 127), rand64(),
                          FIELD_LIMIT - $urandom_range(0, vwbf_pkg::WORD_BITS - 1), hold);
            queue_request(vwbf_pkg::REQ_WRITE, write_width(), rand64(), rand_pos(), 0);
            room = FIELD_LIMIT - plan_cursor;
            if (room < vwbf_pkg::WORD_BITS)
              queue_request(vwbf_pkg::REQ_READ, $urandom_range(room + 1, vwbf_pkg::WORD_BITS),
                            rand64(), rand_pos(), 0);
          end
        endcase
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_requests.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
